@@ design/aat_pkg.sv @@
package aat_pkg;

  localparam int TableDepth = 16;
  localparam int SlotW = $clog2(TableDepth);
  localparam int CountW = $clog2(TableDepth + 1);

  localparam logic [1:0] OpRaise = 2'd0;
  localparam logic [1:0] OpClear = 2'd1;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoSlot = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StInvalid = 2'd3;

  localparam logic [1:0] SevCritical = 2'd3;
  localparam logic [2:0] KindSystem = 3'd4;
  localparam logic [2:0] KindMax = 3'd5;

  localparam logic [1:0] RegModuleCount = 2'd0;
  localparam logic [1:0] RegSystemSource = 2'd1;
  localparam logic [1:0] RegRecordFullCode = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  source;
    logic [15:0] fault_code;
    logic [15:0] instance_req;
    logic [1:0]  severity;
    logic [2:0]  context_kind;
    logic [31:0] now_time;
  } aat_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic        source_active;
    logic [15:0] source_top_code;
    logic        overflow_written;
    logic [4:0]  active_count;
    logic [1:0]  top_severity;
    logic [15:0] top_code;
  } aat_out_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  source;
    logic [15:0] code;
    logic [15:0] inst;
    logic [1:0]  severity;
  } aat_entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PLACE, S_SCAN2, S_PLACE2, S_CLEAR, S_SUM, S_DONE
  } aat_state_t;

endpackage

@@ design/active_alarm_table.sv @@
// Each raise or clear runs a scan pass, a decision state, a summary pass and the
// done strobe. A raise that finds no slot (and is not the record-full code) adds a
// second scan pass and decision state that try to place the record-full alarm; an
// invalid word leaves the scan at once for the summary pass. Busy is low in idle
// after the strobe; a new word is taken only once the last is done. Reset
// (synchronous, rst high) empties the table; the receiver cannot stall.
module active_alarm_table import aat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  aat_in_t     req,
  output logic        done,
  output aat_out_t    result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  // Configuration registers.
  logic [7:0]  module_count;
  logic [7:0]  system_source;
  logic [15:0] record_full_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_count     <= 8'd16;
      system_source    <= 8'd0;
      record_full_code <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegModuleCount:    module_count     <= cfg_data[7:0];
        RegSystemSource:   system_source    <= cfg_data[7:0];
        RegRecordFullCode: record_full_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table storage: key fields and valid bits are per-slot flops; the valid
  // bits clear at reset so invalid slots read as empty.
  logic [TableDepth-1:0] tv;
  logic [7:0]  tsrc  [TableDepth];
  logic [15:0] tcode [TableDepth];
  logic [15:0] tinst [TableDepth];
  logic [1:0]  tsev  [TableDepth];

  aat_state_t state, state_next;
  aat_in_t    r;
  logic [SlotW-1:0] idx;
  logic first;
  logic ovf_try;   // second placement pass for the record-full alarm
  aat_out_t res;

  // Key currently being placed.
  logic [7:0]  k_src;
  logic [15:0] k_code, k_inst;
  logic [1:0]  k_sev;
  assign k_src  = ovf_try ? system_source : r.source;
  assign k_code = ovf_try ? record_full_code : r.fault_code;
  assign k_inst = ovf_try ? 16'd0 : r.instance_req;
  assign k_sev  = ovf_try ? SevCritical : r.severity;

  aat_entry_t ent;
  always_comb begin
    ent.valid    = tv[idx];
    ent.source   = tv[idx] ? tsrc[idx] : 8'd0;
    ent.code     = tv[idx] ? tcode[idx] : 16'd0;
    ent.inst     = tv[idx] ? tinst[idx] : 16'd0;
    ent.severity = tv[idx] ? tsev[idx] : 2'd0;
  end

  logic mf, ff, sa;
  logic [SlotW-1:0] mi, fi, li;
  logic [1:0] ls, ts, ss;
  logic [CountW-1:0] cnt;
  logic [15:0] tc, sc;
  logic last;
  assign last = (idx == SlotW'(TableDepth - 1));

  aat_scan u_scan (
    .clk(clk), .start_scan(first), .idx(idx), .ent(ent),
    .key_source(k_src), .key_code(k_code), .key_inst(k_inst),
    .match_found(mf), .match_idx(mi), .free_found(ff), .free_idx(fi),
    .low_sev(ls), .low_idx(li), .count(cnt), .top_sev(ts), .top_code(tc),
    .src_active(sa), .src_sev(ss), .src_code(sc)
  );

  logic valid_msg;
  always_comb begin
    valid_msg = r.source < module_count && r.fault_code != 16'd0;
    if (r.operation == OpRaise)
      valid_msg = valid_msg && r.severity != 2'd0 && r.context_kind <= KindMax;
    else if (r.operation != OpClear)
      valid_msg = 1'b0;
  end

  // Placement decision from the finished scan.
  logic place_ok;
  logic [SlotW-1:0] place_idx;
  always_comb begin
    place_ok  = 1'b1;
    place_idx = mi;
    if (!mf) begin
      if (ff) place_idx = fi;
      else begin
        place_idx = li;
        place_ok  = k_sev > ls;
      end
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_SCAN;
      S_SCAN: begin
        if (!valid_msg) state_next = S_SUM;
        else if (last)
          state_next = (r.operation == OpRaise) ? S_PLACE : S_CLEAR;
      end
      S_PLACE:  state_next = (place_ok || r.fault_code == record_full_code)
                             ? S_SUM : S_SCAN2;
      S_SCAN2:  if (last) state_next = S_PLACE2;
      S_PLACE2: state_next = S_SUM;
      S_CLEAR:  state_next = S_SUM;
      S_SUM:    if (last) state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    done   = (state == S_DONE);
    result = res;
    result.active_count = 5'(cnt);
    result.top_severity = ts;
    result.top_code     = tc;
  end

  // Entry write-back shares one port driven by the sequencer.
  logic we, wfresh, wclr;
  logic [SlotW-1:0] wi;
  always_comb begin
    we = 1'b0; wfresh = !mf; wclr = 1'b0; wi = place_idx;
    if ((state == S_PLACE || state == S_PLACE2) && place_ok) we = 1'b1;
    if (state == S_CLEAR && mf) begin
      we = 1'b1; wclr = 1'b1; wi = mi;
    end
  end

  logic [2:0]  tkind  [TableDepth];
  logic [31:0] tfirst [TableDepth];
  logic [31:0] tlast  [TableDepth];

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= '0;
    end else if (we) begin
      tv[wi] <= !wclr;
    end
    if (we) begin
      tsrc[wi]  <= wclr ? 8'd0 : k_src;
      tcode[wi] <= wclr ? 16'd0 : k_code;
      tinst[wi] <= wclr ? 16'd0 : k_inst;
      tsev[wi]  <= wclr ? 2'd0 : k_sev;
      tkind[wi] <= wclr ? 3'd0 : (ovf_try ? KindSystem : r.context_kind);
      tlast[wi] <= wclr ? 32'd0 : r.now_time;
      if (wclr || wfresh) tfirst[wi] <= wclr ? 32'd0 : r.now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      first   <= 1'b0;
      ovf_try <= 1'b0;
    end else begin
      state <= state_next;
      first <= 1'b0;
      if (state == S_SCAN || state == S_SCAN2 || state == S_SUM) begin
        idx <= idx + SlotW'(1);
      end
      if (state_next == S_SCAN || state_next == S_SCAN2 ||
          state_next == S_SUM) begin
        if (state_next != state || last) begin
          idx   <= '0;
          first <= 1'b1;
        end
      end
      if (state == S_IDLE) ovf_try <= 1'b0;
      if (state == S_PLACE && state_next == S_SCAN2) ovf_try <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) r <= req;
    unique case (state)
      S_SCAN: res <= {StInvalid, {($bits(aat_out_t) - 2){1'b0}}};
      S_PLACE: begin
        res.status <= place_ok ? StOk : StNoSlot;
        res.slot <= place_ok ? 4'(place_idx) : 4'd0;
        res.source_active <= place_ok;
        res.source_top_code <= place_ok ? r.fault_code : 16'd0;
      end
      S_PLACE2: res.overflow_written <= place_ok;
      S_CLEAR: begin
        res.status <= mf ? StOk : StNotFound;
        res.slot <= mf ? 4'(mi) : 4'd0;
      end
      default: ;
    endcase
    // Source summary comes from the final pass after a clear.
    if (state == S_SUM && last && valid_msg && r.operation == OpClear) begin
      res.source_active   <= sa || (ent.valid && ent.source == r.source);
      res.source_top_code <= (ent.valid && ent.source == r.source &&
                              ent.severity >= ss) ? ent.code : sc;
    end
  end

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    done |-> result.active_count <= 5'(TableDepth)) else $error("count");
endmodule

@@ design/aat_scan.sv @@
module aat_scan import aat_pkg::*; (
  input  logic                 clk,
  input  logic                 start_scan,
  input  logic [SlotW-1:0]     idx,
  input  aat_entry_t           ent,
  input  logic [7:0]           key_source,
  input  logic [15:0]          key_code,
  input  logic [15:0]          key_inst,
  output logic                 match_found,
  output logic [SlotW-1:0]     match_idx,
  output logic                 free_found,
  output logic [SlotW-1:0]     free_idx,
  output logic [1:0]           low_sev,
  output logic [SlotW-1:0]     low_idx,
  output logic [CountW-1:0]    count,
  output logic [1:0]           top_sev,
  output logic [15:0]          top_code,
  output logic                 src_active,
  output logic [1:0]           src_sev,
  output logic [15:0]          src_code
);
  // One entry is visited per cycle; start_scan marks the first entry.
  logic m, f, srcm;
  assign m = ent.valid && ent.source == key_source && ent.code == key_code &&
             ent.inst == key_inst;
  assign f = !ent.valid;
  assign srcm = ent.valid && ent.source == key_source;

  always_ff @(posedge clk) begin
    if (start_scan) begin
      match_found <= m;
      match_idx   <= idx;
      free_found  <= f;
      free_idx    <= idx;
      low_sev     <= ent.severity;
      low_idx     <= idx;
      count       <= CountW'(ent.valid);
      top_sev     <= ent.valid ? ent.severity : 2'd0;
      top_code    <= ent.valid ? ent.code : 16'd0;
      src_active  <= srcm;
      src_sev     <= srcm ? ent.severity : 2'd0;
      src_code    <= srcm ? ent.code : 16'd0;
    end else begin
      if (m && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= idx;
      end
      if (f && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (ent.severity <= low_sev) begin
        low_sev <= ent.severity;
        low_idx <= idx;
      end
      if (ent.valid) begin
        count <= count + CountW'(1);
        if (ent.severity >= top_sev) begin
          top_sev  <= ent.severity;
          top_code <= ent.code;
        end
      end
      if (srcm && ent.severity >= src_sev) begin
        src_active <= 1'b1;
        src_sev    <= ent.severity;
        src_code   <= ent.code;
      end
    end
  end
endmodule
